[rtl/core/json_segment_field_extractor_unit_defines.svh]
// assertion macros shared by the extractor rtl
`ifndef JSON_SEGMENT_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define JSON_SEGMENT_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define JSFE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSFE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define JSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/jsfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jsfe_pkg;

    localparam int TEXT_CAP_DEF    = 4096;
    localparam int NUMBER_BITS_DEF = 48;

    typedef enum logic [3:0] {
        PH_EXPECT,
        PH_IGNORE,
        PH_OUTER,
        PH_OBJ,
        PH_KEY,
        PH_COLON,
        PH_AFTER,
        PH_NWS,
        PH_NSIGN,
        PH_NDIG,
        PH_TEXT,
        PH_ESC,
        PH_USKIP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_CLOSE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        KEY_S,
        KEY_E,
        KEY_T,
        KEY_OTHER
    } t_key;

    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_S      = 8'h73;
    localparam logic [7:0] CH_LC_E      = 8'h65;
    localparam logic [7:0] CH_LC_T      = 8'h74;
    localparam logic [7:0] CH_LC_N      = 8'h6E;
    localparam logic [7:0] CH_LC_R      = 8'h72;
    localparam logic [7:0] CH_LC_U      = 8'h75;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // position of the last hex digit after a unicode escape; this digit is not held
    localparam logic [1:0] USKIP_LAST = 2'd3;

endpackage

`default_nettype wire

[rtl/core/json_segment_field_extractor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "json_segment_field_extractor_unit_defines.svh"

// channel   handshake                    payload
// input     i_in_valid / o_in_stall      i_char_byte, i_is_final
// output    o_out_valid / i_out_stall    o_kind, o_text_char, o_start_ms, o_end_ms,
//                                        o_seg_valid, o_run_last
//
// one byte per cycle when not stalled; a byte without is_final is registered at the input
// and its result in the output buffer; with is_final the parser's end-of-string sequencer
// replays held unicode bytes, emits the close, one step per cycle while the buffer has room
// synchronous active-low reset clears the parse state, start/end go to -1
// two-entry output buffer: input keeps flowing while one result waits under i_out_stall

module json_segment_field_extractor_unit
    import jsfe_pkg::*;
#(
    parameter int P_TEXT_CAP    = TEXT_CAP_DEF,
    parameter int P_NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_char_byte,
    input  logic                     i_is_final,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_kind,
    output logic [7:0]               o_text_char,
    output logic [P_NUMBER_BITS-1:0] o_start_ms,
    output logic [P_NUMBER_BITS-1:0] o_end_ms,
    output logic                     o_seg_valid,
    output logic                     o_run_last
);

    localparam int NB = P_NUMBER_BITS;

    logic          r_in_valid, n_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_fin;

    logic          w_accept;
    logic          w_take;
    logic          w_push;
    t_kind         w_kind;
    logic [7:0]    w_char;
    logic [NB-1:0] w_start;
    logic [NB-1:0] w_end;
    logic          w_segv;
    logic          w_last;
    logic          w_pop;

    logic          r_out_valid, n_out_valid;
    t_kind         r_out_kind, n_out_kind;
    logic [7:0]    r_out_char, n_out_char;
    logic [NB-1:0] r_out_start, n_out_start;
    logic [NB-1:0] r_out_end, n_out_end;
    logic          r_out_segv, n_out_segv;
    logic          r_out_last, n_out_last;

    logic          r_skid_valid, n_skid_valid;
    t_kind         r_skid_kind, n_skid_kind;
    logic [7:0]    r_skid_char, n_skid_char;
    logic [NB-1:0] r_skid_start, n_skid_start;
    logic [NB-1:0] r_skid_end, n_skid_end;
    logic          r_skid_segv, n_skid_segv;
    logic          r_skid_last, n_skid_last;

    assign o_in_stall = r_in_valid && !w_take;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign n_in_valid = w_accept || (r_in_valid && !w_take);

    jsfe_parser #(
        .P_TEXT_CAP    (P_TEXT_CAP),
        .P_NUMBER_BITS (P_NUMBER_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item_byte  (r_in_byte),
        .i_item_fin   (r_in_fin),
        .i_room       (!r_skid_valid),
        .o_take       (w_take),
        .o_push       (w_push),
        .o_kind       (w_kind),
        .o_text_char  (w_char),
        .o_start_ms   (w_start),
        .o_end_ms     (w_end),
        .o_seg_valid  (w_segv),
        .o_run_last   (w_last)
    );

    assign w_pop = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_char   = r_out_char;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_segv   = r_out_segv;
        n_out_last   = r_out_last;
        n_skid_valid = r_skid_valid;
        n_skid_kind  = r_skid_kind;
        n_skid_char  = r_skid_char;
        n_skid_start = r_skid_start;
        n_skid_end   = r_skid_end;
        n_skid_segv  = r_skid_segv;
        n_skid_last  = r_skid_last;

        if (w_pop && r_skid_valid) begin
            n_out_kind   = r_skid_kind;
            n_out_char   = r_skid_char;
            n_out_start  = r_skid_start;
            n_out_end    = r_skid_end;
            n_out_segv   = r_skid_segv;
            n_out_last   = r_skid_last;
            n_skid_valid = 1'b0;
        end else if (w_push && (w_pop || !r_out_valid)) begin
            n_out_valid = 1'b1;
            n_out_kind  = w_kind;
            n_out_char  = w_char;
            n_out_start = w_start;
            n_out_end   = w_end;
            n_out_segv  = w_segv;
            n_out_last  = w_last;
        end else if (w_push) begin
            n_skid_valid = 1'b1;
            n_skid_kind  = w_kind;
            n_skid_char  = w_char;
            n_skid_start = w_start;
            n_skid_end   = w_end;
            n_skid_segv  = w_segv;
            n_skid_last  = w_last;
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_char_byte;
            r_in_fin  <= i_is_final;
        end
        r_out_kind   <= n_out_kind;
        r_out_char   <= n_out_char;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
        r_out_segv   <= n_out_segv;
        r_out_last   <= n_out_last;
        r_skid_kind  <= n_skid_kind;
        r_skid_char  <= n_skid_char;
        r_skid_start <= n_skid_start;
        r_skid_end   <= n_skid_end;
        r_skid_segv  <= n_skid_segv;
        r_skid_last  <= n_skid_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_text_char = r_out_char;
    assign o_start_ms  = r_out_start;
    assign o_end_ms    = r_out_end;
    assign o_seg_valid = r_out_segv;
    assign o_run_last  = r_out_last;

    `JSFE_ASSERT_IMP(a_skid_needs_head, i_clk, i_rst_n,
        r_skid_valid, r_out_valid, "skid entry without head entry")
    `JSFE_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n,
        w_push, !r_skid_valid, "result pushed into full buffer")

endmodule

`default_nettype wire

[rtl/core/jsfe_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "json_segment_field_extractor_unit_defines.svh"

module jsfe_parser
    import jsfe_pkg::*;
#(
    parameter int P_TEXT_CAP    = TEXT_CAP_DEF,
    parameter int P_NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  logic [7:0]               i_item_byte,
    input  logic                     i_item_fin,
    input  logic                     i_room,
    output logic                     o_take,
    output logic                     o_push,
    output t_kind                    o_kind,
    output logic [7:0]               o_text_char,
    output logic [P_NUMBER_BITS-1:0] o_start_ms,
    output logic [P_NUMBER_BITS-1:0] o_end_ms,
    output logic                     o_seg_valid,
    output logic                     o_run_last
);

    localparam int NB = P_NUMBER_BITS;
    localparam int CW = $clog2(P_TEXT_CAP);
    localparam logic [NB-1:0] CAP       = {1'b1, {(NB-1){1'b0}}};
    localparam logic [NB-1:0] CAP_M1    = {1'b0, {(NB-1){1'b1}}};
    localparam logic [NB-1:0] MINUS_ONE = {NB{1'b1}};
    localparam logic [CW-1:0] TRUNC_AT  = CW'(P_TEXT_CAP - 1);

    t_phase        r_phase, n_phase;
    t_key          r_key, n_key;
    logic [NB-1:0] r_start, n_start;
    logic [NB-1:0] r_end, n_end;
    logic [NB-1:0] r_acc, n_acc;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_skip, n_skip;
    logic          r_opened, n_opened;
    logic [7:0]    r_held [0:3];
    logic          r_chain, n_chain;
    logic [1:0]    r_rep_idx, n_rep_idx;
    logic [1:0]    r_rep_n, n_rep_n;

    logic          r_lag_valid, n_lag_valid;
    t_kind         r_lag_kind;
    logic [7:0]    r_lag_char;
    logic [NB-1:0] r_lag_start;
    logic [NB-1:0] r_lag_end;
    logic          r_lag_segv;

    logic          w_go;
    logic          w_replay;
    logic          w_byte_op;
    logic          w_end_op;
    logic [7:0]    w_c;
    logic          w_is_ws;
    logic          w_is_digit;
    logic [3:0]    w_digit;
    logic [NB-1:0] w_acc_in;
    logic          w_neg_in;
    logic [NB+3:0] w_mul10;
    logic [NB-1:0] w_digit_acc;
    logic [NB-1:0] w_fin_val;

    logic          held_we;
    logic          lag_load;
    logic          terminal;
    logic          obj_again;
    logic          num_go;
    t_phase        num_ph;
    logic          res_valid;
    t_kind         res_kind;
    logic [7:0]    res_char;
    logic [NB-1:0] res_start;
    logic [NB-1:0] res_end;
    logic          res_segv;

    assign w_replay  = r_chain && (r_rep_idx != r_rep_n);
    assign w_go      = i_room && (r_chain || i_item_valid);
    assign o_take    = i_room && !r_chain && i_item_valid;
    assign w_byte_op = w_go && (!r_chain || w_replay);
    assign w_end_op  = w_go && r_chain && !w_replay;
    assign w_c       = r_chain ? r_held[r_rep_idx] : i_item_byte;

    assign w_is_ws    = w_c inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign w_is_digit = w_c inside {[CH_ZERO:CH_NINE]};
    assign w_digit    = 4'(w_c - CH_ZERO);

    // a number starts fresh when entered from the value position
    assign w_acc_in = (r_phase == PH_AFTER) ? '0 : r_acc;
    assign w_neg_in = (r_phase == PH_AFTER) ? 1'b0 : r_neg;

    // acc*10+d above the cap saturates to the cap
    assign w_mul10     = ({4'b0000, w_acc_in} << 3) + ({4'b0000, w_acc_in} << 1)
                       + {{NB{1'b0}}, w_digit};
    assign w_digit_acc = (w_mul10 > {4'b0000, CAP}) ? CAP : w_mul10[NB-1:0];
    assign w_fin_val   = w_neg_in ? ({NB{1'b0}} - w_acc_in)
                                  : (w_acc_in[NB-1] ? CAP_M1 : w_acc_in);

    always_comb begin
        n_phase     = r_phase;
        n_key       = r_key;
        n_start     = r_start;
        n_end       = r_end;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_count     = r_count;
        n_skip      = r_skip;
        n_opened    = r_opened;
        n_chain     = r_chain;
        n_rep_idx   = r_rep_idx;
        n_rep_n     = r_rep_n;
        n_lag_valid = r_lag_valid;
        held_we     = 1'b0;
        lag_load    = 1'b0;
        terminal    = 1'b0;
        obj_again   = 1'b0;
        num_go      = 1'b0;
        num_ph      = r_phase;
        res_valid   = 1'b0;
        res_kind    = KIND_CHAR;
        res_char    = '0;
        res_start   = '0;
        res_end     = '0;
        res_segv    = 1'b0;

        if (w_byte_op) begin
            case (r_phase)
                PH_EXPECT: begin
                    n_phase = (w_c == CH_LBRACK) ? PH_OUTER : PH_IGNORE;
                end
                PH_OUTER: begin
                    if (w_c == CH_RBRACK) begin
                        n_phase = PH_IGNORE;
                    end else if (w_c == CH_LBRACE) begin
                        n_start  = MINUS_ONE;
                        n_end    = MINUS_ONE;
                        n_count  = '0;
                        n_opened = 1'b0;
                        n_phase  = PH_OBJ;
                    end
                end
                PH_OBJ: begin
                    obj_again = 1'b1;
                end
                PH_KEY: begin
                    case (w_c)
                        CH_LC_S: n_key = KEY_S;
                        CH_LC_E: n_key = KEY_E;
                        CH_LC_T: n_key = KEY_T;
                        default: n_key = KEY_OTHER;
                    endcase
                    n_phase = (w_c == CH_COLON) ? PH_AFTER : PH_COLON;
                end
                PH_COLON: begin
                    if (w_c == CH_COLON) begin
                        n_phase = PH_AFTER;
                    end
                end
                PH_AFTER: begin
                    if (w_c != CH_SPACE) begin
                        case (r_key)
                            KEY_S, KEY_E: begin
                                num_go = 1'b1;
                            end
                            KEY_T: begin
                                if (w_c == CH_QUOTE) begin
                                    if (r_opened) begin
                                        res_valid = 1'b1;
                                        res_kind  = KIND_RESTART;
                                        n_count   = '0;
                                    end
                                    n_opened = 1'b1;
                                    n_phase  = PH_TEXT;
                                end else begin
                                    n_phase = PH_OBJ;
                                end
                            end
                            default: begin
                                obj_again = 1'b1;
                            end
                        endcase
                    end
                end
                PH_NWS, PH_NSIGN, PH_NDIG: begin
                    num_go = 1'b1;
                end
                PH_TEXT: begin
                    if (r_count >= TRUNC_AT) begin
                        n_phase   = PH_OBJ;
                        obj_again = (w_c != CH_QUOTE);
                    end else if (w_c == CH_QUOTE) begin
                        n_phase = PH_OBJ;
                    end else if (w_c == CH_BACKSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        res_valid = 1'b1;
                        res_char  = w_c;
                        n_count   = r_count + CW'(1);
                    end
                end
                PH_ESC: begin
                    n_phase = PH_TEXT;
                    if (w_c == CH_LC_U) begin
                        n_skip  = '0;
                        n_phase = PH_USKIP;
                    end else begin
                        res_valid = 1'b1;
                        n_count   = r_count + CW'(1);
                        case (w_c)
                            CH_LC_N: res_char = CH_LF;
                            CH_LC_R: res_char = CH_CR;
                            CH_LC_T: res_char = CH_TAB;
                            default: res_char = w_c;
                        endcase
                    end
                end
                PH_USKIP: begin
                    if (r_skip == USKIP_LAST) begin
                        n_skip  = '0;
                        n_phase = PH_TEXT;
                    end else begin
                        held_we = 1'b1;
                        n_skip  = r_skip + 2'd1;
                    end
                end
                default: begin
                end
            endcase

            if (num_go) begin
                num_ph = (r_phase == PH_AFTER) ? PH_NWS : r_phase;
                n_acc  = w_acc_in;
                n_neg  = w_neg_in;
                if (num_ph == PH_NWS && w_is_ws) begin
                    n_phase = PH_NWS;
                end else if (num_ph == PH_NWS && (w_c == CH_PLUS || w_c == CH_MINUS)) begin
                    n_neg   = (w_c == CH_MINUS);
                    n_phase = PH_NSIGN;
                end else if (w_is_digit) begin
                    n_acc   = w_digit_acc;
                    n_phase = PH_NDIG;
                end else begin
                    if (r_key == KEY_S) begin
                        n_start = w_fin_val;
                    end else begin
                        n_end = w_fin_val;
                    end
                    n_acc     = '0;
                    n_neg     = 1'b0;
                    obj_again = 1'b1;
                end
            end

            if (obj_again) begin
                if (w_c == CH_RBRACE) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_CLOSE;
                    n_phase   = PH_OUTER;
                end else if (w_c == CH_QUOTE) begin
                    n_phase = PH_KEY;
                end else begin
                    n_phase = PH_OBJ;
                end
            end

            if (r_chain) begin
                n_rep_idx = r_rep_idx + 2'd1;
            end
        end else if (w_end_op) begin
            // end of string: replay held bytes, flush escape and number, close, then end the sequence
            case (r_phase)
                PH_USKIP: begin
                    n_rep_n   = r_skip;
                    n_rep_idx = '0;
                    n_skip    = '0;
                    n_phase   = PH_TEXT;
                end
                PH_ESC: begin
                    res_valid = 1'b1;
                    res_char  = CH_BACKSLASH;
                    n_count   = r_count + CW'(1);
                    n_phase   = PH_TEXT;
                end
                PH_NWS, PH_NSIGN, PH_NDIG: begin
                    if (r_key == KEY_S) begin
                        n_start = w_fin_val;
                    end else begin
                        n_end = w_fin_val;
                    end
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_phase = PH_OBJ;
                end
                PH_OBJ, PH_KEY, PH_COLON, PH_AFTER, PH_TEXT: begin
                    res_valid = 1'b1;
                    res_kind  = KIND_CLOSE;
                    n_phase   = PH_EXPECT;
                end
                default: begin
                    n_phase  = PH_EXPECT;
                    terminal = 1'b1;
                    n_chain  = 1'b0;
                end
            endcase
        end

        if (res_valid && res_kind == KIND_CLOSE) begin
            res_start = n_start;
            res_end   = n_end;
            res_segv  = !n_start[NB-1] && ($signed(n_end) > $signed(n_start))
                        && (r_count != '0);
        end

        if (o_take && i_item_fin) begin
            n_chain   = 1'b1;
            n_rep_idx = '0;
            n_rep_n   = '0;
        end

        // results of a final byte wait one place so the last one can be marked
        o_push      = 1'b0;
        o_kind      = res_kind;
        o_text_char = res_char;
        o_start_ms  = res_start;
        o_end_ms    = res_end;
        o_seg_valid = res_segv;
        o_run_last  = 1'b1;
        if (o_take && !i_item_fin) begin
            o_push = res_valid;
        end else if (w_go && (terminal || res_valid)) begin
            o_push      = r_lag_valid;
            o_kind      = r_lag_kind;
            o_text_char = r_lag_char;
            o_start_ms  = r_lag_start;
            o_end_ms    = r_lag_end;
            o_seg_valid = r_lag_segv;
            o_run_last  = terminal;
            n_lag_valid = !terminal;
            lag_load    = !terminal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_EXPECT;
            r_key       <= KEY_OTHER;
            r_start     <= MINUS_ONE;
            r_end       <= MINUS_ONE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_count     <= '0;
            r_skip      <= '0;
            r_opened    <= 1'b0;
            r_chain     <= 1'b0;
            r_rep_idx   <= '0;
            r_rep_n     <= '0;
            r_lag_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_key       <= n_key;
            r_start     <= n_start;
            r_end       <= n_end;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_count     <= n_count;
            r_skip      <= n_skip;
            r_opened    <= n_opened;
            r_chain     <= n_chain;
            r_rep_idx   <= n_rep_idx;
            r_rep_n     <= n_rep_n;
            r_lag_valid <= n_lag_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held[r_skip] <= w_c;
        end
        if (lag_load) begin
            r_lag_kind  <= res_kind;
            r_lag_char  <= res_char;
            r_lag_start <= res_start;
            r_lag_end   <= res_end;
            r_lag_segv  <= res_segv;
        end
    end

    `JSFE_ASSERT_IMP(a_lag_empty_at_start, i_clk, i_rst_n, o_take && !i_item_fin, !r_lag_valid, "held result left over at item start")
    `JSFE_ASSERT_IMP(a_replay_bound, i_clk, i_rst_n, r_chain, r_rep_idx <= r_rep_n, "replay index past held count")
    `JSFE_ASSERT_IMP(a_idle_replay_done, i_clk, i_rst_n, !r_chain, r_rep_idx == r_rep_n, "replay pending while idle")
    `JSFE_ASSERT_NEXT(a_fin_enters_end, i_clk, i_rst_n, o_take && i_item_fin, r_chain, "final byte did not start end sequence")

endmodule

`default_nettype wire
